/* rtl/cda_pkg.sv */
package cda_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int OFFS_W  = 12;
   localparam int WDAY_W  = 3;

   // shared divide unit: 15-bit dividend by one of two constant divisors,
   // quotient from a reciprocal scaled by 2^RCP_SHIFT and rounded up
   localparam int DIV_W     = 15;
   localparam int REM_W     = 7;
   localparam int RCP_W     = 17;
   localparam int RCP_SHIFT = 19;
   localparam int CENT_Q_W  = 8;

   localparam logic [REM_W-1:0]   DIVISOR_CENTURY = 7'd100;
   localparam logic [REM_W-1:0]   DIVISOR_WEEK    = 7'd7;
   localparam logic [RCP_W-1:0]   RECIP_CENTURY   = 17'd5243;
   localparam logic [RCP_W-1:0]   RECIP_WEEK      = 17'd74899;
   localparam logic [REM_W-1:0]   CENTURY_LAST    = 7'd99;
   localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  in_year;
      logic [MONTH_W-1:0] in_month;
      logic [DAY_W-1:0]   in_day;
      logic [OFFS_W-1:0]  day_offset;
   } req_type;

   typedef struct packed {
      logic               date_valid;
      logic [WDAY_W-1:0]  weekday;
      logic [YEAR_W-1:0]  out_year;
      logic [MONTH_W-1:0] out_month;
      logic [DAY_W-1:0]   out_day;
   } rsp_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // 3 * (m + 1) / 5 for m counted from March = 3 to February = 14
   function automatic logic [3:0] march_term(input logic [MONTH_W:0] m);
      logic [3:0] t;
      case (m)
         5'd3:    t = 4'd2;
         5'd4:    t = 4'd3;
         5'd5:    t = 4'd3;
         5'd6:    t = 4'd4;
         5'd7:    t = 4'd4;
         5'd8:    t = 4'd5;
         5'd9:    t = 4'd6;
         5'd10:   t = 4'd6;
         5'd11:   t = 4'd7;
         5'd12:   t = 4'd7;
         5'd13:   t = 4'd8;
         5'd14:   t = 4'd9;
         default: t = 4'd0;
      endcase
      return t;
   endfunction

endpackage

/* rtl/cda_div.sv */
module cda_div (
   input  logic                         clock,
   input  logic                         reset,
   input  cda_pkg::div_ctl_type         ctl,
   input  logic [cda_pkg::DIV_W-1:0]    dividend,
   input  logic [cda_pkg::REM_W-1:0]    divisor,
   output cda_pkg::div_stat_type        stat,
   output logic [cda_pkg::DIV_W-1:0]    quotient,
   output logic [cda_pkg::REM_W-1:0]    remainder
);
   import cda_pkg::*;

   localparam int PROD_W = DIV_W + RCP_W;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 phase_ff;
   logic [DIV_W-1:0]     num_ff;
   logic [REM_W-1:0]     dsr_ff;
   logic [RCP_W-1:0]     rcp_ff;
   logic [DIV_W-1:0]     quot_ff;
   logic [REM_W-1:0]     rem_ff;

   logic [RCP_W-1:0]     rcp_in;
   logic [PROD_W-1:0]    prod;
   logic [DIV_W-1:0]     quot_in;
   logic [DIV_W-1:0]     back;
   logic [DIV_W-1:0]     diff;

   always_comb begin
      case (divisor)
         DIVISOR_CENTURY: rcp_in = RECIP_CENTURY;
         DIVISOR_WEEK:    rcp_in = RECIP_WEEK;
         default:         rcp_in = '0;
      endcase
      // quotient from the scaled reciprocal, remainder by multiplying back
      prod    = {{RCP_W{1'b0}}, num_ff} * {{DIV_W{1'b0}}, rcp_ff};
      quot_in = DIV_W'(prod[PROD_W-1:RCP_SHIFT]);
      back    = quot_ff * {{(DIV_W-REM_W){1'b0}}, dsr_ff};
      diff    = num_ff - back;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
            num_ff   <= dividend;
            dsr_ff   <= divisor;
            rcp_ff   <= rcp_in;
         end else if (busy_ff) begin
            phase_ff <= 1'b1;
            if (!phase_ff) begin
               quot_ff <= quot_in;
            end else begin
               rem_ff  <= diff[REM_W-1:0];
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/calendar_date_add_weekday.sv */
// Gregorian date checker, day-of-week and day adder.
// req channel: one item holds year, month, day and a day offset; it is taken
// when req_valid and req_ready are both high. rsp channel: one item per request
// with the validity flag, the weekday (0 = Monday) and the shifted date.
// Only one request is worked on at a time; req_ready is high between requests,
// also while a finished response still waits on rsp.
// Per item, the work is two passes through the shared divide unit
// (year / 100 for the leap and century terms, then the weekday sum mod 7),
// plus intake, checking, summing, walk exit and output; the month walk is
// one compare and subtract a cycle, one step per month boundary crossed.
// An invalid date skips both the weekday pass and the walk.
// Reset (synchronous) returns the sequencer to idle and drops any pending
// response. When the receiver stalls, the response is held in the output
// register; one more request may be taken and worked on, and its result waits
// until the register frees.
module calendar_date_add_weekday #(
   parameter int OFFSET_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cda_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cda_pkg::rsp_type rsp_item
);
   import cda_pkg::*;

   localparam int OB_EFF = (OFFSET_BITS < OFFS_W) ? OFFSET_BITS : OFFS_W;
   localparam int ODW    = OB_EFF + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_YEAR,
      ST_CHECK,
      ST_WSUM_A,
      ST_WSUM_B,
      ST_DIV_WEEK,
      ST_STEP,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [DAY_W-1:0]    day_ff;
   logic [OB_EFF-1:0]   offs_ff;

   logic                valid_ff;
   logic [WDAY_W-1:0]   wday_ff;
   logic [YEAR_W-1:0]   oy_ff;
   logic [MONTH_W-1:0]  om_ff;
   logic [ODW-1:0]      od_ff;
   logic [REM_W-1:0]    cent_rem_ff;
   logic [1:0]          cent_q_ff;

   logic [6:0]          dm_ff;
   logic [YEAR_W-1:0]   yp_ff;
   logic [CENT_Q_W-1:0] qp_ff;
   logic                yzero_ff;
   logic [DIV_W-1:0]    acc_ff;

   div_ctl_type         div_ctl_ff;
   logic [DIV_W-1:0]    div_num_ff;
   logic [REM_W-1:0]    div_dsr_ff;
   div_stat_type        div_stat;
   logic [DIV_W-1:0]    div_quot;
   logic [REM_W-1:0]    div_rem;

   cda_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl_ff),
      .dividend  (div_num_ff),
      .divisor   (div_dsr_ff),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   logic [CENT_Q_W-1:0] q100;
   logic                leap_in;
   logic                valid_in;
   logic                early_in;
   logic [MONTH_W:0]    mp_in;
   logic                leap_cur;
   logic [DAY_W-1:0]    mlen_cur;
   logic [ODW-1:0]      mlen_ext;

   always_comb begin
      q100     = div_quot[CENT_Q_W-1:0];
      leap_in  = ((year_ff[1:0] == 2'd0) && (div_rem != '0)) ||
                 ((div_rem == '0) && (q100[1:0] == 2'd0));
      valid_in = (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                 (day_ff != '0) && (day_ff <= month_days(month_ff, leap_in));
      early_in = month_ff <= MONTH_FEB;
      mp_in    = early_in ? ({1'b0, month_ff} + 5'd12) : {1'b0, month_ff};
      // leap test of the running year from its century counters
      leap_cur = ((oy_ff[1:0] == 2'd0) && (cent_rem_ff != '0)) ||
                 ((cent_rem_ff == '0) && (cent_q_ff == 2'd0));
      mlen_cur = month_days(om_ff, leap_cur);
      mlen_ext = ODW'(mlen_cur);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_ctl_ff   <= '0;
      end else begin
         div_ctl_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  year_ff          <= req_item.in_year;
                  month_ff         <= req_item.in_month;
                  day_ff           <= req_item.in_day;
                  offs_ff          <= req_item.day_offset[OB_EFF-1:0];
                  div_num_ff       <= DIV_W'(req_item.in_year);
                  div_dsr_ff       <= DIVISOR_CENTURY;
                  div_ctl_ff.start <= 1'b1;
                  state_ff         <= ST_DIV_YEAR;
               end
            end
            ST_DIV_YEAR: begin
               if (div_stat.done && !div_stat.busy) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               valid_ff    <= valid_in;
               wday_ff     <= '0;
               oy_ff       <= year_ff;
               om_ff       <= month_ff;
               cent_rem_ff <= div_rem;
               cent_q_ff   <= q100[1:0];
               dm_ff       <= 7'(day_ff) + 7'({mp_in, 1'b0}) + 7'(march_term(mp_in));
               yzero_ff    <= 1'b0;
               yp_ff       <= year_ff;
               qp_ff       <= q100;
               if (early_in) begin
                  // January and February belong to the previous year
                  if (year_ff == '0) begin
                     yzero_ff <= 1'b1;
                     yp_ff    <= '0;
                     qp_ff    <= '0;
                  end else begin
                     yp_ff <= year_ff - 1'b1;
                     if (div_rem == '0) begin
                        qp_ff <= q100 - 1'b1;
                     end
                  end
               end
               if (valid_in) begin
                  od_ff    <= ODW'(day_ff) + ODW'(offs_ff);
                  state_ff <= ST_WSUM_A;
               end else begin
                  od_ff    <= ODW'(day_ff);
                  state_ff <= ST_FINISH;
               end
            end
            ST_WSUM_A: begin
               acc_ff   <= DIV_W'(dm_ff) + DIV_W'(yp_ff) + DIV_W'(yp_ff[YEAR_W-1:2])
                           - DIV_W'(yzero_ff);
               state_ff <= ST_WSUM_B;
            end
            ST_WSUM_B: begin
               div_num_ff       <= acc_ff - DIV_W'(qp_ff) + DIV_W'(qp_ff[CENT_Q_W-1:2]);
               div_dsr_ff       <= DIVISOR_WEEK;
               div_ctl_ff.start <= 1'b1;
               state_ff         <= ST_DIV_WEEK;
            end
            ST_DIV_WEEK: begin
               if (div_stat.done && !div_stat.busy) begin
                  wday_ff  <= div_rem[WDAY_W-1:0];
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               // advance one month while the day count overruns it
               if (od_ff > mlen_ext) begin
                  od_ff <= od_ff - mlen_ext;
                  if (om_ff == MONTH_DEC) begin
                     om_ff <= MONTH_JAN;
                     oy_ff <= oy_ff + 1'b1;
                     if (cent_rem_ff == CENTURY_LAST) begin
                        cent_rem_ff <= '0;
                        cent_q_ff   <= cent_q_ff + 1'b1;
                     end else begin
                        cent_rem_ff <= cent_rem_ff + 1'b1;
                     end
                  end else begin
                     om_ff <= om_ff + 1'b1;
                  end
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.date_valid <= valid_ff;
                  rsp_ff.weekday    <= wday_ff;
                  rsp_ff.out_year   <= oy_ff;
                  rsp_ff.out_month  <= om_ff;
                  rsp_ff.out_day    <= od_ff[DAY_W-1:0];
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* test/calendar_date_add_weekday_tb.sv */
`timescale 1ns / 1ps

module calendar_date_add_weekday_tb;
   import cda_pkg::*;

   localparam int OFFSET_BITS  = 12;
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 300;
   localparam int LIMIT_CYCLES = 2_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   int cycle_count = 0;
   int burst_left  = 0;
   int ready_mode  = 0;
   int stall_run   = 0;

   always #5 clock = ~clock;

   calendar_date_add_weekday #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   function automatic bit is_leap_year(int y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int month_length(int y, int m);
      if (m == 2) begin
         return is_leap_year(y) ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

   class date_scoreboard;
      rsp_type expected_dates[$];
      int      errors = 0;

      function rsp_type shifted_date(req_type r);
         rsp_type e;
         int      y, m, d, s;
         int      yr, mo, dy, offs;
         e.date_valid = 1'b0;
         e.weekday    = '0;
         e.out_year   = r.in_year;
         e.out_month  = r.in_month;
         e.out_day    = r.in_day;
         if (r.in_month >= 1 && r.in_month <= 12 && r.in_day >= 1 &&
             r.in_day <= month_length(int'(r.in_year), int'(r.in_month))) begin
            e.date_valid = 1'b1;
            // January and February count as months 13 and 14 of the year before
            y = int'(r.in_year);
            m = int'(r.in_month);
            d = int'(r.in_day);
            if (m <= 2) begin
               m = m + 12;
               y = y - 1;
            end
            s = d + 2 * m + 3 * (m + 1) / 5 + y + y / 4 - y / 100 + y / 400;
            e.weekday = WDAY_W'(s % 7);
            offs = int'(r.day_offset) & ((1 << OFFSET_BITS) - 1);
            yr = int'(r.in_year);
            mo = int'(r.in_month);
            dy = int'(r.in_day) + offs;
            while (dy > month_length(yr, mo)) begin
               dy = dy - month_length(yr, mo);
               mo = mo + 1;
               if (mo > 12) begin
                  mo = 1;
                  yr = yr + 1;
               end
            end
            // year wraps at the field width
            e.out_year  = YEAR_W'(yr);
            e.out_month = MONTH_W'(mo);
            e.out_day   = DAY_W'(dy);
         end
         return e;
      endfunction

      function void note_request(req_type r);
         expected_dates.push_back(shifted_date(r));
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_dates.size() == 0) begin
            $error("response with no request outstanding: %h", a);
            errors++;
            return;
         end
         e = expected_dates.pop_front();
         if (a.date_valid !== e.date_valid) begin
            $error("date_valid: expected %0d, got %0d", e.date_valid, a.date_valid);
            errors++;
         end
         if (a.weekday !== e.weekday) begin
            $error("weekday: expected %0d, got %0d", e.weekday, a.weekday);
            errors++;
         end
         if (a.out_year !== e.out_year) begin
            $error("out_year: expected %0d, got %0d", e.out_year, a.out_year);
            errors++;
         end
         if (a.out_month !== e.out_month) begin
            $error("out_month: expected %0d, got %0d", e.out_month, a.out_month);
            errors++;
         end
         if (a.out_day !== e.out_day) begin
            $error("out_day: expected %0d, got %0d", e.out_day, a.out_day);
            errors++;
         end
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   date_scoreboard dates = new();

   function automatic req_type make_request(int y, int m, int d, int offs);
      req_type r;
      r.in_year    = YEAR_W'(y);
      r.in_month   = MONTH_W'(m);
      r.in_day     = DAY_W'(d);
      r.day_offset = OFFS_W'(offs);
      return r;
   endfunction

   function automatic req_type random_request();
      int pick, ysel, osel, yr, mo, dy, offs, len;
      int special_years[14] = '{0, 1, 4, 100, 400, 1600, 1700, 1900, 2000, 2100,
                                2400, 9999, 16380, 16383};
      pick = $urandom_range(99);
      ysel = $urandom_range(99);
      osel = $urandom_range(99);
      if (ysel < 65) begin
         yr = $urandom_range(9999, 1);
      end else if (ysel < 82) begin
         yr = $urandom_range(16383);
      end else begin
         yr = special_years[$urandom_range(13)];
      end
      if (osel < 50) begin
         offs = $urandom_range(4095);
      end else if (osel < 75) begin
         offs = $urandom_range(60);
      end else begin
         offs = $urandom_range(4095, 3800);
      end
      mo  = $urandom_range(12, 1);
      len = month_length(yr, mo);
      if (pick < 78) begin
         dy = $urandom_range(len, 1);
      end else if (pick < 88) begin
         // just outside the month
         dy = ($urandom_range(1) == 0) ? 0 : len + 1;
      end else begin
         mo = $urandom_range(15);
         dy = $urandom_range(31);
      end
      return make_request(yr, mo, dy, offs);
   endfunction

   // hold valid through a burst, drop it for a random gap between bursts
   task automatic send_request(input req_type r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                : $urandom_range(8, 1);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);
      dates.note_request(r);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // check the item taken at this edge, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         dates.check_response(rsp_item);
      end
      if (cycle_count % 400 == 0) begin
         ready_mode = $urandom_range(2);
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(1) == 1);
         default: begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(25, 1);
               rsp_ready <= ~rsp_ready;
            end else begin
               stall_run--;
            end
         end
      endcase
   end

   initial begin
      req_type directed[$];
      directed.push_back(make_request(2024, 2, 29, 0));
      directed.push_back(make_request(1900, 2, 29, 0));
      directed.push_back(make_request(2000, 2, 29, 365));
      directed.push_back(make_request(0, 1, 1, 0));
      directed.push_back(make_request(0, 2, 29, 1));
      directed.push_back(make_request(16383, 12, 31, 4095));
      directed.push_back(make_request(1, 1, 1, 4095));
      directed.push_back(make_request(9999, 12, 31, 1));
      directed.push_back(make_request(2023, 0, 1, 10));
      directed.push_back(make_request(2023, 13, 1, 10));
      directed.push_back(make_request(16383, 15, 31, 4095));
      directed.push_back(make_request(2023, 4, 31, 5));
      directed.push_back(make_request(2023, 1, 0, 5));
      directed.push_back(make_request(0, 0, 0, 0));
      directed.push_back(make_request(2023, 1, 31, 28));
      directed.push_back(make_request(2023, 12, 31, 0));
      directed.push_back(make_request(2100, 2, 28, 1));
      directed.push_back(make_request(2400, 2, 28, 1));
      directed.push_back(make_request(2023, 3, 1, 4095));
      directed.push_back(make_request(1999, 11, 30, 31));
      directed.push_back(make_request(16383, 2, 28, 4095));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_request(directed[i]);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_request(random_request());
      end
      req_valid <= 1'b0;

      while (dates.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (dates.errors == 0 && dates.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
